// File: hw/rtl/pcmenc_pkg.sv
// Shared types, format codes and scale constants for the PCM sample encoder.
// No dependencies; every file but pcmenc_if imports this package.
`default_nettype none

package pcmenc_pkg;

    localparam int FMT_W   = 3;
    localparam int PROD_W  = 55;
    localparam int MANT_W  = 24;
    localparam int SCALE_W = 31;
    localparam int MAG_W   = 86;
    localparam int ADDR_W  = 3;

    localparam logic [FMT_W-1:0] FMT_INT8    = 3'd0;
    localparam logic [FMT_W-1:0] FMT_INT16   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_INT24   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_FLOAT64 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RESET   = FMT_FLOAT32;

    localparam logic [0:0] REG_FORMAT = 1'b0;

    localparam logic [SCALE_W-1:0] FULL_SCALE_I8  = 31'd127;
    localparam logic [SCALE_W-1:0] FULL_SCALE_I16 = 31'd32767;
    localparam logic [SCALE_W-1:0] FULL_SCALE_I32 = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic [7:0]        exp_eff;
        logic [PROD_W-1:0] prod;
        logic [31:0]       bits;
        logic              last;
    } t_scaled;

    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic signed [8:0] shr;
        logic [PROD_W-1:0] q;
        logic [31:0]       bits;
        logic              last;
    } t_rounded;

endpackage

`default_nettype wire

// File: hw/rtl/pcmenc_if.sv
// Stream interfaces for sample input and encoded byte output.
// Depends on nothing beyond plain logic types.
`default_nettype none

interface pcmenc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_bits;
    logic        last_sample;

    modport source (output valid, output sample_bits, output last_sample, input ready);
    modport sink (input valid, input sample_bits, input last_sample, output ready);
endinterface

interface pcmenc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] pcm_bytes;
    logic [3:0]  byte_count;
    logic        last_group;

    modport source (output valid, output pcm_bytes, output byte_count, output last_group,
                    input ready);
    modport sink (input valid, input pcm_bytes, input byte_count, input last_group,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcmenc_cfg.sv
// APB register block holding the output format register.
// Depends on pcmenc_pkg.
`default_nettype none

module pcmenc_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pcmenc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [pcmenc_pkg::FMT_W-1:0] o_fmt
);
    import pcmenc_pkg::*;

    logic [FMT_W-1:0] r_fmt;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FORMAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RESET;
        end else if (wr_en) begin
            r_fmt <= pwdata[FMT_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FORMAT: prdata = {{(32-FMT_W){1'b0}}, r_fmt};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_fmt = r_fmt;
endmodule

`default_nettype wire

// File: hw/rtl/pcmenc_scale.sv
// Input register and mantissa-by-full-scale multiply stage.
// Depends on pcmenc_pkg and pcmenc_in_if.
`default_nettype none

module pcmenc_scale (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pcmenc_pkg::FMT_W-1:0] i_fmt,
    pcmenc_in_if.sink                       i_sample,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output pcmenc_pkg::t_scaled             o_data
);
    import pcmenc_pkg::*;

    logic               r_a_valid;
    logic [31:0]        r_a_bits;
    logic               r_a_last;
    logic               r_b_valid;
    t_scaled            r_b;
    t_scaled            n_b;
    logic               ld_a;
    logic               ld_b;
    logic [7:0]         exp_f;
    logic [MANT_W-1:0]  mant;
    logic [SCALE_W-1:0] scale;

    assign ld_b           = !r_b_valid || i_ready;
    assign ld_a           = !r_a_valid || ld_b;
    assign i_sample.ready = ld_a;

    always_comb begin
        case (i_fmt)
            FMT_INT8:  scale = FULL_SCALE_I8;
            FMT_INT16: scale = FULL_SCALE_I16;
            default:   scale = FULL_SCALE_I32;
        endcase
        exp_f       = r_a_bits[30:23];
        mant        = {exp_f != 8'd0, r_a_bits[22:0]};
        n_b.sign    = r_a_bits[31];
        n_b.nan     = (exp_f == 8'hFF) && (r_a_bits[22:0] != 23'd0);
        n_b.inf     = (exp_f == 8'hFF) && (r_a_bits[22:0] == 23'd0);
        n_b.exp_eff = (exp_f == 8'd0) ? 8'd1 : exp_f;
        n_b.prod    = PROD_W'(mant) * PROD_W'(scale);
        n_b.bits    = r_a_bits;
        n_b.last    = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ld_a) begin
                r_a_valid <= i_sample.valid;
            end
            if (ld_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a && i_sample.valid) begin
            r_a_bits <= i_sample.sample_bits;
            r_a_last <= i_sample.last_sample;
        end
        if (ld_b && r_a_valid) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;
endmodule

`default_nettype wire

// File: hw/rtl/pcmenc_round.sv
// Precision rounding stage: rounds the scaled product to float or double precision.
// Depends on pcmenc_pkg.
`default_nettype none

module pcmenc_round (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pcmenc_pkg::FMT_W-1:0] i_fmt,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  pcmenc_pkg::t_scaled             i_data,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output pcmenc_pkg::t_rounded            o_data
);
    import pcmenc_pkg::*;

    logic              r_valid;
    t_rounded          r_data;
    t_rounded          n_data;
    logic              ld;
    logic [5:0]        lead;
    logic [5:0]        prec;
    logic [5:0]        k_sh;
    logic [PROD_W-1:0] mask_k;
    logic [PROD_W-1:0] mask_h;
    logic [PROD_W-1:0] kept;
    logic              half;
    logic              sticky;
    logic              inc;

    assign ld      = !r_valid || i_ready;
    assign o_ready = ld;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < PROD_W; i++) begin
            if (i_data.prod[i]) begin
                lead = 6'(i);
            end
        end
        prec   = (i_fmt == FMT_INT24) ? 6'd53 : 6'd24;
        k_sh   = (lead >= prec) ? (lead - prec + 6'd1) : 6'd0;
        mask_k = (PROD_W'(1) << k_sh) - PROD_W'(1);
        mask_h = mask_k >> 1;
        kept   = i_data.prod >> k_sh;
        half   = |(i_data.prod & mask_k & ~mask_h);
        sticky = |(i_data.prod & mask_h);
        inc    = half && (sticky || kept[0]);

        n_data.sign = i_data.sign;
        n_data.nan  = i_data.nan;
        n_data.inf  = i_data.inf;
        n_data.shr  = 9'sd150 - $signed({1'b0, i_data.exp_eff}) - $signed({3'b0, k_sh});
        n_data.q    = kept + PROD_W'(inc);
        n_data.bits = i_data.bits;
        n_data.last = i_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

`default_nettype wire

// File: hw/rtl/pcmenc_pack.sv
// Integer rounding, saturation, float widening and the output register.
// Depends on pcmenc_pkg and pcmenc_out_if.
`default_nettype none

module pcmenc_pack (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pcmenc_pkg::FMT_W-1:0] i_fmt,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  pcmenc_pkg::t_rounded            i_data,
    pcmenc_out_if.source                    o_pcm
);
    import pcmenc_pkg::*;

    logic              r_valid;
    logic [63:0]       r_bytes;
    logic [3:0]        r_count;
    logic              r_last;
    logic [63:0]       n_bytes;
    logic [3:0]        n_count;
    logic              ld;
    logic [56:0]       q_ext;
    logic [56:0]       mask_r;
    logic [56:0]       mask_h;
    logic [56:0]       ipart;
    logic              half;
    logic              sticky;
    logic              inc;
    logic [8:0]        shl;
    logic [MAG_W-1:0]  mag;
    logic              big;
    logic [31:0]       hi;
    logic [31:0]       val;
    logic [7:0]        exp_f;
    logic [22:0]       frac;
    logic [4:0]        lead;
    logic [4:0]        nshift;
    logic [22:0]       frac_n;
    logic [10:0]       exp_d;
    logic [51:0]       mant_d;
    logic [63:0]       wide;

    assign ld      = !r_valid || o_pcm.ready;
    assign o_ready = ld;

    always_comb begin
        q_ext  = {2'b0, i_data.q};
        mask_r = 57'd0;
        mask_h = 57'd0;
        ipart  = 57'd0;
        half   = 1'b0;
        sticky = 1'b0;
        inc    = 1'b0;
        shl    = 9'd0;
        mag    = '0;
        big    = 1'b0;
        if (!i_data.shr[8]) begin
            if (i_data.shr <= 9'sd56) begin
                mask_r = (57'd1 << i_data.shr[5:0]) - 57'd1;
                mask_h = mask_r >> 1;
                ipart  = q_ext >> i_data.shr[5:0];
                half   = |(q_ext & mask_r & ~mask_h);
                sticky = |(q_ext & mask_h);
                inc    = half && (sticky || ipart[0]);
                mag    = MAG_W'(ipart) + MAG_W'(inc);
            end
        end else begin
            shl = 9'(-i_data.shr);
            if (shl > 9'd31) begin
                big = (i_data.q != '0);
            end else begin
                mag = MAG_W'(i_data.q) << shl[4:0];
            end
        end

        case (i_fmt)
            FMT_INT8:  hi = 32'(FULL_SCALE_I8);
            FMT_INT16: hi = 32'(FULL_SCALE_I16);
            default:   hi = 32'(FULL_SCALE_I32);
        endcase

        if (i_data.nan) begin
            val = 32'd0;
        end else if (!i_data.sign) begin
            if (i_data.inf || big || mag > MAG_W'(hi)) begin
                val = hi;
            end else begin
                val = mag[31:0];
            end
        end else begin
            if (i_data.inf || big || mag > (MAG_W'(hi) + MAG_W'(1))) begin
                val = ~hi;
            end else begin
                val = 32'd0 - mag[31:0];
            end
        end

        exp_f = i_data.bits[30:23];
        frac  = i_data.bits[22:0];
        lead  = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) begin
                lead = 5'(i);
            end
        end
        nshift = 5'd23 - lead;
        frac_n = 23'(frac << nshift);
        if (exp_f == 8'hFF) begin
            exp_d  = 11'h7FF;
            mant_d = {frac, 29'd0} | {(frac != 23'd0), 51'd0};
        end else if (exp_f == 8'd0) begin
            if (frac == 23'd0) begin
                exp_d  = 11'd0;
                mant_d = 52'd0;
            end else begin
                exp_d  = 11'd897 - 11'(nshift);
                mant_d = {frac_n, 29'd0};
            end
        end else begin
            exp_d  = 11'(exp_f) + 11'd896;
            mant_d = {frac, 29'd0};
        end
        wide = {i_data.bits[31], exp_d, mant_d};

        case (i_fmt)
            FMT_INT8: begin
                n_bytes = {56'd0, val[7:0]};
                n_count = 4'd1;
            end
            FMT_INT16: begin
                n_bytes = {48'd0, val[15:0]};
                n_count = 4'd2;
            end
            FMT_INT24: begin
                n_bytes = {40'd0, val[31:8]};
                n_count = 4'd3;
            end
            FMT_FLOAT64: begin
                n_bytes = wide;
                n_count = 4'd8;
            end
            default: begin
                n_bytes = {32'd0, i_data.bits};
                n_count = 4'd4;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && i_valid) begin
            r_bytes <= n_bytes;
            r_count <= n_count;
            r_last  <= i_data.last;
        end
    end

    assign o_pcm.valid      = r_valid;
    assign o_pcm.pcm_bytes  = r_bytes;
    assign o_pcm.byte_count = r_count;
    assign o_pcm.last_group = r_last;
endmodule

`default_nettype wire

// File: hw/rtl/pcm_sample_encoder.sv
// Top level of the PCM sample encoder: register block and four-register pipeline.
// Depends on pcmenc_pkg, pcmenc_if, pcmenc_cfg, pcmenc_scale, pcmenc_round, pcmenc_pack.
//
// Usage:
//   i_sample takes one float32 sample (sample_bits) and a frame-end flag per transfer.
//   o_pcm gives one transfer per sample: right-aligned big-endian bytes in pcm_bytes,
//   their number in byte_count and the copied flag in last_group.
//   The APB port holds one register at offset 0: the output format
//   (0 int8, 1 int16, 2 int24, 3 float32, 4 float64). Write it only while idle.
// Path: a sample passes the input register, multiply register, precision-round register
//   and output register.
// Throughput: one sample per cycle while o_pcm.ready stays high; every stage accepts
//   new data as the next one drains.
// Reset: all pipeline stages empty, format set to float32.
// Stall: when o_pcm.ready is low the output holds; upstream stages keep filling until
//   each holds data, then i_sample.ready drops.
`default_nettype none

module pcm_sample_encoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pcmenc_in_if.sink                          i_sample,
    pcmenc_out_if.source                       o_pcm,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcmenc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import pcmenc_pkg::*;

    logic [FMT_W-1:0] fmt;
    logic             scl_valid;
    logic             scl_ready;
    t_scaled          scl_data;
    logic             rnd_valid;
    logic             rnd_ready;
    t_rounded         rnd_data;

    pcmenc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_fmt   (fmt)
    );

    pcmenc_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fmt    (fmt),
        .i_sample (i_sample),
        .o_valid  (scl_valid),
        .i_ready  (scl_ready),
        .o_data   (scl_data)
    );

    pcmenc_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (fmt),
        .i_valid (scl_valid),
        .o_ready (scl_ready),
        .i_data  (scl_data),
        .o_valid (rnd_valid),
        .i_ready (rnd_ready),
        .o_data  (rnd_data)
    );

    pcmenc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (fmt),
        .i_valid (rnd_valid),
        .o_ready (rnd_ready),
        .i_data  (rnd_data),
        .o_pcm   (o_pcm)
    );
endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for pcm_sample_encoder: float32 samples in, big-endian PCM bytes out.
// Depends on pcmenc_pkg, pcmenc_if and the encoder RTL; a scoreboard class holds the
// format-aware predictor and the queue of encodings still owed by the block.
`default_nettype none

module testbench;
    import pcmenc_pkg::*;

    typedef struct {
        logic [63:0] pcm_bytes;
        logic [3:0]  byte_count;
        logic        last_group;
    } t_encoding;

    class pcm_scoreboard;
        logic [FMT_W-1:0] fmt;
        t_encoding        owed[$];
        int               errors;
        int               checked;
        int               per_fmt[8];

        function new();
            fmt = FMT_RESET;
            errors = 0;
            checked = 0;
            foreach (per_fmt[i]) per_fmt[i] = 0;
        endfunction

        function automatic logic [63:0] widen(logic [31:0] b);
            logic [63:0] s;
            logic [7:0]  e;
            logic [63:0] m;
            int          ex;
            s = {b[31], 63'd0};
            e = b[30:23];
            m = {41'd0, b[22:0]};
            if (e == 8'hFF)
                return s | (64'h7FF << 52) | (m << 29) | ((m != 0) ? (64'd1 << 51) : 64'd0);
            if (e == 0) begin
                if (m == 0) return s;
                ex = 1;
                while (m[23] == 1'b0) begin
                    m = m << 1;
                    ex = ex - 1;
                end
                m[63:23] = '0;
            end else begin
                ex = e;
            end
            return s | (64'(ex + 896) << 52) | (m << 29);
        endfunction

        function automatic real to_single(real d);
            logic [63:0] w;
            logic [28:0] low;
            w = $realtobits(d);
            low = w[28:0];
            w[28:0] = '0;
            if (low > 29'h1000_0000 || (low == 29'h1000_0000 && w[29])) w = w + (64'd1 << 29);
            return $bitstoreal(w);
        endfunction

        function automatic longint round_clamp(real x, longint lo, longint hi);
            longint t;
            real    fr;
            if (x >= hi) return hi;
            if (x <= lo) return lo;
            t = $rtoi(x);
            fr = x - t;
            if (fr > 0.5 || (fr == 0.5 && t[0])) t = t + 1;
            else if (fr < -0.5 || (fr == -0.5 && t[0])) t = t - 1;
            return t;
        endfunction

        function automatic t_encoding encode(logic [31:0] b, logic lst);
            t_encoding   r;
            logic        nan;
            logic        inf;
            real         x;
            longint      v;
            nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
            inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
            x = $bitstoreal(widen(b));
            r.last_group = lst;
            r.pcm_bytes = '0;
            case (fmt)
                FMT_INT8: begin
                    if (nan) v = 0;
                    else if (inf) v = b[31] ? -128 : 127;
                    else v = round_clamp(to_single(x * 127.0), -128, 127);
                    r.pcm_bytes[7:0] = v[7:0];
                    r.byte_count = 4'd1;
                end
                FMT_INT16: begin
                    if (nan) v = 0;
                    else if (inf) v = b[31] ? -32768 : 32767;
                    else v = round_clamp(to_single(x * 32767.0), -32768, 32767);
                    r.pcm_bytes[15:0] = v[15:0];
                    r.byte_count = 4'd2;
                end
                FMT_INT24: begin
                    if (nan) v = 0;
                    else if (inf) v = b[31] ? -64'sd2147483648 : 64'sd2147483647;
                    else v = round_clamp(x * 2147483647.0, -64'sd2147483648, 64'sd2147483647);
                    r.pcm_bytes[23:0] = v[31:8];
                    r.byte_count = 4'd3;
                end
                FMT_FLOAT64: begin
                    r.pcm_bytes = widen(b);
                    r.byte_count = 4'd8;
                end
                default: begin
                    r.pcm_bytes[31:0] = b;
                    r.byte_count = 4'd4;
                end
            endcase
            return r;
        endfunction

        function void note_sample(logic [31:0] b, logic lst);
            owed.push_back(encode(b, lst));
            per_fmt[fmt]++;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_encoding(logic [63:0] pb, logic [3:0] cnt, logic lg);
            t_encoding e;
            checked++;
            if (owed.size() == 0) begin
                report($sformatf("unexpected transfer bytes=%h", pb));
                return;
            end
            e = owed.pop_front();
            if (pb !== e.pcm_bytes)
                report($sformatf("pcm_bytes %h, want %h", pb, e.pcm_bytes));
            if (cnt !== e.byte_count)
                report($sformatf("byte_count %0d, want %0d", cnt, e.byte_count));
            if (lg !== e.last_group)
                report($sformatf("last_group %b, want %b", lg, e.last_group));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    bit                no_idle = 1'b0;
    pcm_scoreboard     sb = new();

    pcmenc_in_if  in_ch();
    pcmenc_out_if out_ch();

    pcm_sample_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(in_ch),
        .o_pcm   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample_bits = '0;
        in_ch.last_sample = 1'b0;
        out_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_format(logic [FMT_W-1:0] f);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = '0;
        pwdata = {29'd0, f};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.fmt = f;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_sample(logic [31:0] b, logic lst);
        int g;
        if (!in_ch.valid) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.sample_bits = b;
        in_ch.last_sample = lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_sample(b, lst);
        g = gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            in_ch.valid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        if (in_ch.valid) begin
            in_ch.valid = 1'b0;
        end
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_sample();
        int          r;
        logic [31:0] b;
        r = $urandom_range(0, 99);
        b = $urandom();
        if (r < 45) b[30:23] = 8'($urandom_range(100, 127));
        else if (r < 60) begin
            b[30:23] = 8'($urandom_range(110, 127));
            b[15:0] = '0;
        end else if (r < 70)
            b[30:0] = 31'h7F80_0000 | (($urandom_range(0, 1)) ? {8'd0, b[22:0]} : 31'd0);
        else if (r < 78) b[30:23] = 8'd0;
        return b;
    endfunction

    logic [31:0] special_samples[14] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
        32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h807F_FFFF, 32'h7F7F_FFFF, 32'h3F00_0000, 32'h4000_0000
    };

    logic [FMT_W-1:0] fmt_plan[9] = '{
        FMT_FLOAT32, FMT_INT8, FMT_INT16, FMT_INT24, FMT_FLOAT64,
        3'd5, 3'd7, 3'd6, FMT_INT16
    };

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (no_idle) out_ch.ready <= 1'b1;
            else if ($urandom_range(0, 99) < 4) out_ch.ready <= 1'b0;
            else if (!out_ch.ready && $urandom_range(0, 99) < 85) out_ch.ready <= 1'b0;
            else out_ch.ready <= $urandom_range(0, 99) < 80;
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_encoding(out_ch.pcm_bytes, out_ch.byte_count, out_ch.last_group);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 5000) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int p = 0; p < 9; p++) begin
            if (p > 0) begin
                drain();
                write_format(fmt_plan[p]);
            end
            no_idle = (p == 3);
            foreach (special_samples[i])
                send_sample(special_samples[i], i[0]);
            for (int n = 0; n < 136; n++)
                send_sample(random_sample(), $urandom_range(0, 7) == 0);
        end
        drain();
        $display("covered %0d transfers over %0d format settings", sb.checked, 9);
        $display("per format 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", sb.per_fmt[0],
                 sb.per_fmt[1], sb.per_fmt[2], sb.per_fmt[3], sb.per_fmt[4],
                 sb.per_fmt[5], sb.per_fmt[6], sb.per_fmt[7]);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
